FILE: design/min_cost_bipartite_assignment_assert.svh
`ifndef MIN_COST_BIPARTITE_ASSIGNMENT_ASSERT_SVH
`define MIN_COST_BIPARTITE_ASSIGNMENT_ASSERT_SVH

// Property that must hold in the same cycle as its condition.
`define MCBA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mcba: same-cycle property violated");

// Property that must hold in the cycle after its condition.
`define MCBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mcba: next-cycle property violated");

`endif

FILE: design/mcba_pkg.sv
package mcba_pkg;

    localparam int MAX_SIDE = 16;
    localparam int SIDE_W   = $clog2(MAX_SIDE);
    localparam int COST_W   = 16;
    localparam int DIST_W   = 23;
    localparam int TOTAL_W  = 20;
    localparam int COUNT_W  = 5;
    localparam int ADDR_W   = 2 * SIDE_W;
    localparam int CIDX_W   = 1;

    localparam logic [CIDX_W-1:0] CFG_BOX_COUNT  = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_GOAL_COUNT = 1'b1;

    typedef struct packed {
        logic [SIDE_W-1:0]        tag;
        logic                     matched;
        logic [SIDE_W-1:0]        mgoal;
        logic                     dfin;
        logic signed [DIST_W-1:0] path_dist;
    } t_box_ent;

    typedef struct packed {
        logic [SIDE_W-1:0]        tag;
        logic                     matched;
        logic [SIDE_W-1:0]        mbox;
        logic                     dfin;
        logic signed [DIST_W-1:0] path_dist;
        logic [SIDE_W-1:0]        par;
    } t_goal_ent;

    typedef struct packed {
        logic init_solve;
        logic init_search;
        logic relax;
        logic shift_box;
        logic pass_restart;
        logic find_clear;
        logic find;
        logic pick;
        logic seek_goal;
        logic seek_box;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic changed;
        logic found;
        logic hit_goal;
        logic hit_box;
        logic more;
        logic out_busy;
    } t_status;

endpackage

FILE: design/min_cost_bipartite_assignment.sv
// Channel  Direction  Handshake                Payload
// input    in         i_valid / o_stall        i_box_index i_goal_index i_distance i_last
// result   out        o_valid / i_stall        o_total_cost o_assigned_count
// config   in         i_cfg_valid / o_cfg_ready  i_cfg_index i_cfg_data
//
// Non-last cost entries stream at one per cycle while no solve is running.
// A last entry starts a solve: each search runs Bellman-Ford passes over the cost
// memory port until no distance changes, then a sink scan and a path walk.
// Reset is synchronous and active low; no clearing pass is needed after it.
// Input stalls during a solve; a pending result may wait while new entries load.
module min_cost_bipartite_assignment (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mcba_pkg::SIDE_W-1:0]         i_box_index,
    input  logic [mcba_pkg::SIDE_W-1:0]         i_goal_index,
    input  logic [mcba_pkg::COST_W-1:0]         i_distance,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mcba_pkg::TOTAL_W-1:0]        o_total_cost,
    output logic [mcba_pkg::COUNT_W-1:0]        o_assigned_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mcba_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [mcba_pkg::COUNT_W-1:0]        i_cfg_data
);

    mcba_pkg::t_cmd    cmd;
    mcba_pkg::t_status status;
    logic              busy;
    logic              in_accept;

    assign o_stall     = busy;
    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_valid && !busy;

    mcba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_accept (in_accept),
        .i_in_last   (i_last),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (busy)
    );

    mcba_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_accept      (in_accept),
        .i_box_index      (i_box_index),
        .i_goal_index     (i_goal_index),
        .i_distance       (i_distance),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_take       (o_valid && !i_stall),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_total_cost     (o_total_cost),
        .o_assigned_count (o_assigned_count)
    );

endmodule

FILE: design/mcba_ctrl.sv
module mcba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_accept,
    input  logic             i_in_last,
    input  mcba_pkg::t_status i_status,
    output mcba_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_SOLVE, S_INIT, S_RD, S_RELAX, S_ROW, S_PASS_END,
        S_FIND, S_PICK, S_SEEKG, S_SEEKB, S_DONE
    } t_state;

    localparam logic [mcba_pkg::SIDE_W-1:0] LAST_IDX =
        mcba_pkg::SIDE_W'(mcba_pkg::MAX_SIDE - 1);

    t_state                      r_state;
    logic [mcba_pkg::SIDE_W-1:0] r_col;
    logic [mcba_pkg::SIDE_W-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_accept && i_in_last) begin
                        r_state <= S_SOLVE;
                    end
                end
                S_SOLVE: r_state <= S_INIT;
                S_INIT: begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_RELAX;
                S_RELAX: begin
                    r_col   <= r_col + 1'b1;
                    r_state <= (r_col == LAST_IDX) ? S_ROW : S_RD;
                end
                S_ROW: begin
                    r_row   <= r_row + 1'b1;
                    r_state <= (r_row == LAST_IDX) ? S_PASS_END : S_RD;
                end
                S_PASS_END: begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_state <= i_status.changed ? S_RD : S_FIND;
                end
                S_FIND: begin
                    r_col <= r_col + 1'b1;
                    if (r_col == LAST_IDX) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: r_state <= i_status.found ? S_SEEKG : S_DONE;
                S_SEEKG: begin
                    if (i_status.hit_goal) begin
                        r_state <= S_SEEKB;
                    end
                end
                S_SEEKB: begin
                    if (i_status.hit_box) begin
                        r_state <= i_status.more ? S_SEEKG : S_INIT;
                    end
                end
                S_DONE: begin
                    if (!i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd              = '0;
        o_cmd.init_solve   = (r_state == S_SOLVE);
        o_cmd.init_search  = (r_state == S_INIT);
        o_cmd.relax        = (r_state == S_RELAX);
        o_cmd.shift_box    = (r_state == S_ROW);
        o_cmd.pass_restart = (r_state == S_PASS_END) && i_status.changed;
        o_cmd.find_clear   = (r_state == S_PASS_END) && !i_status.changed;
        o_cmd.find         = (r_state == S_FIND);
        o_cmd.pick         = (r_state == S_PICK);
        o_cmd.seek_goal    = (r_state == S_SEEKG);
        o_cmd.seek_box     = (r_state == S_SEEKB);
        o_cmd.load_out     = (r_state == S_DONE) && !i_status.out_busy;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: design/mcba_dp.sv
module mcba_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_accept,
    input  logic [mcba_pkg::SIDE_W-1:0]         i_box_index,
    input  logic [mcba_pkg::SIDE_W-1:0]         i_goal_index,
    input  logic [mcba_pkg::COST_W-1:0]         i_distance,
    input  logic                                i_cfg_write,
    input  logic [mcba_pkg::CIDX_W-1:0]         i_cfg_index,
    input  logic [mcba_pkg::COUNT_W-1:0]        i_cfg_data,
    input  logic                                i_out_take,
    input  mcba_pkg::t_cmd                      i_cmd,
    output mcba_pkg::t_status                   o_status,
    output logic                                o_valid,
    output logic [mcba_pkg::TOTAL_W-1:0]        o_total_cost,
    output logic [mcba_pkg::COUNT_W-1:0]        o_assigned_count
);

    localparam int N = mcba_pkg::MAX_SIDE;
    localparam logic [mcba_pkg::COUNT_W-1:0] SIDE_CAP = mcba_pkg::COUNT_W'(N);

    logic [mcba_pkg::COST_W-1:0]  mem [N*N];
    logic [mcba_pkg::COST_W-1:0]  r_cost;

    mcba_pkg::t_box_ent  r_box  [N];
    mcba_pkg::t_goal_ent r_goal [N];

    logic [mcba_pkg::COUNT_W-1:0] r_box_count;
    logic [mcba_pkg::COUNT_W-1:0] r_goal_count;
    logic                         r_changed;
    logic                         r_best_fin;
    logic signed [mcba_pkg::DIST_W-1:0] r_best_dist;
    logic [mcba_pkg::SIDE_W-1:0]  r_best_tag;
    logic [mcba_pkg::SIDE_W-1:0]  r_target_g;
    logic [mcba_pkg::SIDE_W-1:0]  r_target_b;
    logic [mcba_pkg::TOTAL_W-1:0] r_total;
    logic [mcba_pkg::COUNT_W-1:0] r_flow;
    logic                         r_o_valid;
    logic [mcba_pkg::TOTAL_W-1:0] r_o_total;
    logic [mcba_pkg::COUNT_W-1:0] r_o_count;

    mcba_pkg::t_box_ent  b0, b_upd;
    mcba_pkg::t_goal_ent g0, g_upd;
    logic [mcba_pkg::COUNT_W-1:0] nb, ng;
    logic signed [mcba_pkg::DIST_W-1:0] cost_ext, fwd_sum, bwd_sum;
    logic pair_ok, is_flow, fwd_ok, bwd_ok, find_ok, hit_g, hit_b;

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            mem[{i_box_index, i_goal_index}] <= i_distance;
        end
        r_cost <= mem[{r_box[0].tag, r_goal[0].tag}];
    end

    always_comb begin
        b0       = r_box[0];
        g0       = r_goal[0];
        nb       = (r_box_count > SIDE_CAP) ? SIDE_CAP : r_box_count;
        ng       = (r_goal_count > SIDE_CAP) ? SIDE_CAP : r_goal_count;
        cost_ext = $signed({{(mcba_pkg::DIST_W - mcba_pkg::COST_W){1'b0}}, r_cost});
        fwd_sum  = b0.path_dist + cost_ext;
        bwd_sum  = g0.path_dist - cost_ext;
        pair_ok  = ({1'b0, b0.tag} < nb) && ({1'b0, g0.tag} < ng);
        is_flow  = g0.matched && (g0.mbox == b0.tag);
        fwd_ok   = pair_ok && !is_flow && b0.dfin && (!g0.dfin || fwd_sum < g0.path_dist);
        bwd_ok   = pair_ok && is_flow && g0.dfin && (!b0.dfin || bwd_sum < b0.path_dist);
        find_ok  = ({1'b0, g0.tag} < ng) && !g0.matched && g0.dfin
                   && (!r_best_fin || g0.path_dist < r_best_dist);
        hit_g    = (g0.tag == r_target_g);
        hit_b    = (b0.tag == r_target_b);
        g_upd    = g0;
        b_upd    = b0;
        if (fwd_ok) begin
            g_upd.dfin      = 1'b1;
            g_upd.path_dist = fwd_sum;
            g_upd.par       = b0.tag;
        end
        if (bwd_ok) begin
            b_upd.dfin      = 1'b1;
            b_upd.path_dist = bwd_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_count  <= mcba_pkg::COUNT_W'(1);
            r_goal_count <= mcba_pkg::COUNT_W'(1);
            r_o_valid    <= 1'b0;
            r_changed    <= 1'b0;
            r_best_fin   <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                unique case (i_cfg_index)
                    mcba_pkg::CFG_BOX_COUNT:  r_box_count  <= i_cfg_data;
                    mcba_pkg::CFG_GOAL_COUNT: r_goal_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_take) begin
                r_o_valid <= 1'b0;
            end
            if (i_cmd.init_search || i_cmd.pass_restart) begin
                r_changed <= 1'b0;
            end else if (i_cmd.relax && (fwd_ok || bwd_ok)) begin
                r_changed <= 1'b1;
            end
            if (i_cmd.find_clear) begin
                r_best_fin <= 1'b0;
            end else if (i_cmd.find && find_ok) begin
                r_best_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_total <= r_total;
            r_o_count <= r_flow;
        end
        if (i_cmd.find && find_ok) begin
            r_best_dist <= g0.path_dist;
            r_best_tag  <= g0.tag;
        end
        if (i_cmd.init_solve) begin
            r_total <= '0;
            r_flow  <= '0;
        end else if (i_cmd.pick && r_best_fin) begin
            r_total    <= r_total + r_best_dist[mcba_pkg::TOTAL_W-1:0];
            r_flow     <= r_flow + 1'b1;
            r_target_g <= r_best_tag;
        end
        if (i_cmd.seek_goal && hit_g) begin
            r_target_b <= g0.par;
        end
        if (i_cmd.seek_box && hit_b && b0.matched) begin
            r_target_g <= b0.mgoal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_solve) begin
            for (int i = 0; i < N; i++) begin
                r_box[i]  <= '{tag: mcba_pkg::SIDE_W'(i), default: '0};
                r_goal[i] <= '{tag: mcba_pkg::SIDE_W'(i), default: '0};
            end
        end else if (i_cmd.init_search) begin
            for (int i = 0; i < N; i++) begin
                r_box[i].dfin      <= !r_box[i].matched && ({1'b0, r_box[i].tag} < nb);
                r_box[i].path_dist <= '0;
                r_goal[i].dfin     <= 1'b0;
            end
        end else if (i_cmd.relax || i_cmd.find || (i_cmd.seek_goal && !hit_g)) begin
            for (int i = 0; i < N - 1; i++) begin
                r_goal[i] <= r_goal[i+1];
            end
            r_goal[N-1] <= i_cmd.relax ? g_upd : g0;
            if (i_cmd.relax) begin
                r_box[0] <= b_upd;
            end
        end else if (i_cmd.seek_goal) begin
            r_goal[0].matched <= 1'b1;
            r_goal[0].mbox    <= g0.par;
        end else if (i_cmd.shift_box || (i_cmd.seek_box && !hit_b)) begin
            for (int i = 0; i < N - 1; i++) begin
                r_box[i] <= r_box[i+1];
            end
            r_box[N-1] <= b0;
        end else if (i_cmd.seek_box) begin
            r_box[0].matched <= 1'b1;
            r_box[0].mgoal   <= r_target_g;
        end
    end

    always_comb begin
        o_status          = '0;
        o_status.changed  = r_changed;
        o_status.found    = r_best_fin;
        o_status.hit_goal = hit_g;
        o_status.hit_box  = hit_b;
        o_status.more     = b0.matched;
        o_status.out_busy = r_o_valid;
    end

    assign o_valid          = r_o_valid;
    assign o_total_cost     = r_o_total;
    assign o_assigned_count = r_o_count;

endmodule

FILE: design/mcba_checker.sv
`include "min_cost_bipartite_assignment_assert.svh"

module mcba_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                i_last,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [mcba_pkg::TOTAL_W-1:0]        o_total_cost,
    input logic [mcba_pkg::COUNT_W-1:0]        o_assigned_count
);

    `MCBA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `MCBA_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_total_cost) && $stable(o_assigned_count))
    `MCBA_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid,
        o_assigned_count <= mcba_pkg::COUNT_W'(mcba_pkg::MAX_SIDE))
    `MCBA_ASSERT_NOW(a_empty_free, i_clk, i_rst_n, o_valid && (o_assigned_count == '0),
        o_total_cost == '0)
    `MCBA_ASSERT_NEXT(a_last_solves, i_clk, i_rst_n, i_valid && !o_stall && i_last, o_stall)

endmodule

bind min_cost_bipartite_assignment mcba_checker u_mcba_checker (.*);

FILE: test/min_cost_bipartite_assignment_test.sv
module min_cost_bipartite_assignment_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcba_pkg::*;

    localparam int  NUM_VERTS    = 2 * MAX_SIDE + 2;
    localparam longint DIST_HUGE = 64'd1 << 40;
    localparam int  RANDOM_ITEMS = 900;
    localparam longint CYCLE_LIMIT = 64'd30_000_000;
    localparam int  HOLD_CYCLES  = 4000;
    localparam int  SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } t_assignment;

    typedef enum logic {ROW_ENTRY, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [CIDX_W-1:0]  reg_index;
        logic [COUNT_W-1:0] reg_data;
        logic [SIDE_W-1:0]  box;
        logic [SIDE_W-1:0]  goal;
        logic [COST_W-1:0]  cost;
        logic               last;
        logic               known;
        logic [TOTAL_W-1:0] total;
        logic [COUNT_W-1:0] count;
    } t_dir_row;

    localparam int NUM_ROWS = 21;
    localparam t_dir_row DIR_ROWS [NUM_ROWS] = '{
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'd0, 1'b1, 1'b1, 20'd0, 5'd1},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'hFFFF, 1'b1, 1'b1, 20'd65535, 5'd1},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd15, 4'd15, 16'hFFFF, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'd9, 1'b1, 1'b1, 20'd9, 5'd1},
        '{ROW_REG, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd5, 4'd10, 16'd100, 1'b1, 1'b1, 20'd0, 5'd0},
        '{ROW_REG, CFG_BOX_COUNT, 5'd31, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_REG, CFG_GOAL_COUNT, 5'd0, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'd1, 1'b1, 1'b1, 20'd0, 5'd0},
        '{ROW_REG, CFG_BOX_COUNT, 5'd2, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_REG, CFG_GOAL_COUNT, 5'd2, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'd1, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd1, 16'd2, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd1, 4'd0, 16'd2, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd1, 4'd1, 16'd100, 1'b1, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd0, 16'hFFFF, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd0, 4'd1, 16'hFFFF, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd1, 4'd0, 16'hFFFF, 1'b0, 1'b0, 20'd0, 5'd0},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd1, 4'd1, 16'hFFFF, 1'b1, 1'b1, 20'd131070, 5'd2},
        '{ROW_ENTRY, CFG_BOX_COUNT, 5'd0, 4'd1, 4'd1, 16'd0, 1'b1, 1'b0, 20'd0, 5'd0},
        '{ROW_REG, CFG_GOAL_COUNT, 5'd1, 4'd0, 4'd0, 16'd0, 1'b0, 1'b0, 20'd0, 5'd0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [SIDE_W-1:0]    i_box_index;
    logic [SIDE_W-1:0]    i_goal_index;
    logic [COST_W-1:0]    i_distance;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_stall;
    logic [TOTAL_W-1:0]   o_total_cost;
    logic [COUNT_W-1:0]   o_assigned_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index;
    logic [COUNT_W-1:0]   i_cfg_data;

    min_cost_bipartite_assignment DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_box_index     (i_box_index),
        .i_goal_index    (i_goal_index),
        .i_distance      (i_distance),
        .i_last          (i_last),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_total_cost    (o_total_cost),
        .o_assigned_count(o_assigned_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Mirror of the block's state.
    logic [COST_W-1:0]  cost_mirror [MAX_SIDE*MAX_SIDE];
    logic [COUNT_W-1:0] box_count_reg;
    logic [COUNT_W-1:0] goal_count_reg;
    bit                 pair_used [MAX_SIDE*MAX_SIDE];
    bit                 end_used [2*MAX_SIDE];
    longint             vert_pot [NUM_VERTS];
    longint             vert_dist [NUM_VERTS];
    int                 vert_parent [NUM_VERTS];
    bit                 vert_done [NUM_VERTS];

    t_assignment pending_assignments [$];
    int          error_count;
    int          items_sent;
    int          results_seen;
    longint      cycle_count;
    bit          quiet_sender;
    bit          quiet_receiver;
    bit          hold_done;
    int          hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string msg);
        error_count++;
        if (error_count <= 50) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endtask

    function automatic int side_size(input logic [COUNT_W-1:0] raw);
        return (raw > MAX_SIDE) ? MAX_SIDE : int'(raw);
    endfunction

    function automatic bit residual(input int u, input int v, input int nb, input int ng,
                                    output longint w);
        int  t;
        int  k;
        bit  u_box;
        bit  v_box;
        bit  u_goal;
        bit  v_goal;
        t = nb + ng + 1;
        u_box = (u >= 1 && u <= nb);
        v_box = (v >= 1 && v <= nb);
        u_goal = (u > nb && u < t);
        v_goal = (v > nb && v < t);
        w = 0;
        if (u == 0 && v_box) return !end_used[v-1];
        if (u_box && v == 0) return end_used[u-1];
        if (u_box && v_goal) begin
            k = (u - 1) * MAX_SIDE + (v - nb - 1);
            w = longint'(cost_mirror[k]);
            return !pair_used[k];
        end
        if (u_goal && v_box) begin
            k = (v - 1) * MAX_SIDE + (u - nb - 1);
            w = -longint'(cost_mirror[k]);
            return pair_used[k];
        end
        if (u_goal && v == t) return !end_used[MAX_SIDE + (u - nb - 1)];
        if (u == t && v_goal) return end_used[MAX_SIDE + (v - nb - 1)];
        return 1'b0;
    endfunction

    function automatic bit cheapest_path(input int nb, input int ng);
        int     n;
        int     t;
        int     u;
        longint best;
        longint w;
        longint nd;
        longint d;
        n = nb + ng + 2;
        t = n - 1;
        for (int i = 0; i < n; i++) begin
            vert_dist[i] = DIST_HUGE;
            vert_parent[i] = -1;
            vert_done[i] = 1'b0;
        end
        vert_dist[0] = 0;
        forever begin
            best = DIST_HUGE;
            u = -1;
            for (int i = 0; i < n; i++) begin
                if (!vert_done[i] && vert_dist[i] < best) begin
                    best = vert_dist[i];
                    u = i;
                end
            end
            if (u < 0) break;
            vert_done[u] = 1'b1;
            for (int v = 0; v < n; v++) begin
                if (!vert_done[v] && residual(u, v, nb, ng, w)) begin
                    nd = vert_dist[u] + w + vert_pot[u] - vert_pot[v];
                    if (nd < vert_dist[v]) begin
                        vert_dist[v] = nd;
                        vert_parent[v] = u;
                    end
                end
            end
        end
        if (vert_dist[t] >= DIST_HUGE) return 1'b0;
        for (int i = 0; i < n; i++) begin
            d = (vert_dist[i] > vert_dist[t]) ? vert_dist[t] : vert_dist[i];
            vert_pot[i] += d;
        end
        return 1'b1;
    endfunction

    function automatic t_assignment predict_assignment();
        t_assignment res;
        int     nb;
        int     ng;
        int     t;
        int     u;
        int     v;
        int     k;
        longint total;
        int     flow;
        nb = side_size(box_count_reg);
        ng = side_size(goal_count_reg);
        t = nb + ng + 1;
        total = 0;
        flow = 0;
        foreach (pair_used[i]) pair_used[i] = 1'b0;
        foreach (end_used[i]) end_used[i] = 1'b0;
        foreach (vert_pot[i]) vert_pot[i] = 0;
        if (nb > 0 && ng > 0) begin
            while (cheapest_path(nb, ng)) begin
                v = t;
                while (v != 0) begin
                    u = vert_parent[v];
                    if (u < 0) break;
                    if (u == 0) begin
                        end_used[v-1] = 1'b1;
                    end else if (v == 0) begin
                        end_used[u-1] = 1'b0;
                    end else if (v == t) begin
                        end_used[MAX_SIDE + (u - nb - 1)] = 1'b1;
                    end else if (u == t) begin
                        end_used[MAX_SIDE + (v - nb - 1)] = 1'b0;
                    end else if (u <= nb) begin
                        k = (u - 1) * MAX_SIDE + (v - nb - 1);
                        pair_used[k] = 1'b1;
                        total += longint'(cost_mirror[k]);
                    end else begin
                        k = (v - 1) * MAX_SIDE + (u - nb - 1);
                        pair_used[k] = 1'b0;
                        total -= longint'(cost_mirror[k]);
                    end
                    v = u;
                end
                flow++;
            end
        end
        if (total < 0) total = 0;
        res.total = total[TOTAL_W-1:0];
        res.count = flow[COUNT_W-1:0];
        return res;
    endfunction

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_assignments.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_BOX_COUNT) box_count_reg = data;
        else goal_count_reg = data;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic put_entry(input logic [SIDE_W-1:0] box, input logic [SIDE_W-1:0] goal,
                             input logic [COST_W-1:0] dist_val, input logic last,
                             input bit known, input t_assignment known_res);
        if (!quiet_sender && $urandom_range(0, 99) < 11) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_box_index <= box;
        i_goal_index <= goal;
        i_distance <= dist_val;
        i_last <= last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        cost_mirror[{box, goal}] = dist_val;
        if (last) begin
            pending_assignments.push_back(known ? known_res : predict_assignment());
        end
    endtask

    function automatic logic [COST_W-1:0] pick_distance(input int style);
        case (style)
            0: return COST_W'($urandom);
            1: return COST_W'($urandom_range(0, 15));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    task automatic run_phase(input logic [COUNT_W-1:0] boxes, input logic [COUNT_W-1:0] goals,
                             input int matrices);
        int          nb;
        int          ng;
        int          style;
        int          npairs;
        int          j;
        int          tmp;
        int          order [MAX_SIDE*MAX_SIDE];
        t_assignment none;
        none = '0;
        write_reg(CFG_BOX_COUNT, boxes);
        write_reg(CFG_GOAL_COUNT, goals);
        nb = side_size(boxes);
        ng = side_size(goals);
        for (int m = 0; m < matrices; m++) begin
            style = $urandom_range(0, 2);
            if (nb == 0 || ng == 0) begin
                put_entry(SIDE_W'($urandom), SIDE_W'($urandom), pick_distance(0), 1'b1, 0, none);
            end else if (m == 0 || $urandom_range(0, 2) == 0) begin
                npairs = nb * ng;
                for (int i = 0; i < npairs; i++) order[i] = (i / ng) * MAX_SIDE + (i % ng);
                for (int i = npairs - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (int i = 0; i < npairs; i++) begin
                    if ($urandom_range(0, 99) < 8) begin
                        put_entry(SIDE_W'($urandom), SIDE_W'($urandom), pick_distance(0), 1'b0,
                                  0, none);
                    end
                    put_entry(SIDE_W'(order[i] / MAX_SIDE), SIDE_W'(order[i] % MAX_SIDE),
                              pick_distance(style), i == npairs - 1, 0, none);
                end
            end else begin
                npairs = $urandom_range(1, nb * ng);
                for (int i = 0; i < npairs; i++) begin
                    put_entry(SIDE_W'($urandom_range(0, nb - 1)), SIDE_W'($urandom_range(0, ng - 1)),
                              pick_distance(style), i == npairs - 1, 0, none);
                end
            end
        end
    endtask

    initial begin
        t_assignment row_res;
        int          r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_box_index = '0;
        i_goal_index = '0;
        i_distance = '0;
        i_last = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BOX_COUNT;
        i_cfg_data = '0;
        error_count = 0;
        items_sent = 0;
        results_seen = 0;
        quiet_sender = 1'b0;
        box_count_reg = 5'd1;
        goal_count_reg = 5'd1;
        foreach (cost_mirror[i]) cost_mirror[i] = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (DIR_ROWS[i].kind == ROW_REG) begin
                write_reg(DIR_ROWS[i].reg_index, DIR_ROWS[i].reg_data);
            end else begin
                row_res.total = DIR_ROWS[i].total;
                row_res.count = DIR_ROWS[i].count;
                put_entry(DIR_ROWS[i].box, DIR_ROWS[i].goal, DIR_ROWS[i].cost,
                          DIR_ROWS[i].last, DIR_ROWS[i].known, row_res);
            end
        end

        run_phase(5'd16, 5'd16, 1);
        while (items_sent < NUM_ROWS + RANDOM_ITEMS) begin
            quiet_sender = (items_sent >= 400 && items_sent < 550);
            r = $urandom_range(0, 99);
            if (r < 5) begin
                run_phase($urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(1, 4)), 5'd0, 2);
            end else if (r < 10) begin
                run_phase(5'($urandom_range(17, 31)), 5'($urandom_range(1, 2)), 2);
            end else if (r < 15) begin
                run_phase(5'($urandom_range(1, 2)), 5'($urandom_range(17, 31)), 2);
            end else if (r < 25) begin
                run_phase(5'($urandom_range(1, 8)), 5'($urandom_range(1, 8)),
                          $urandom_range(1, 3));
            end else begin
                run_phase(5'($urandom_range(1, 5)), 5'($urandom_range(1, 5)),
                          $urandom_range(1, 4));
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_assignments.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        i_stall = 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            quiet_receiver = (results_seen >= 40 && results_seen < 60);
            if (!hold_done && results_seen == 25) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !quiet_receiver && ($urandom_range(0, 99) < 11);
            end
        end
    end

    always @(posedge i_clk) begin
        t_assignment want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_assignments.size() == 0) begin
                report($sformatf("unexpected result total %0d count %0d",
                                 o_total_cost, o_assigned_count));
            end else begin
                want = pending_assignments.pop_front();
                if (o_total_cost !== want.total) begin
                    report($sformatf("total_cost %0d, expected %0d", o_total_cost, want.total));
                end
                if (o_assigned_count !== want.count) begin
                    report($sformatf("assigned_count %0d, expected %0d",
                                     o_assigned_count, want.count));
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule
